// ----- src/assert_macros.svh -----
// Concurrent assertion helpers; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// cond must hold at every clock edge out of reset
`define SBX_ASSERT(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
// cons must hold in the cycle after ante
`define SBX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SBX_ASSERT(lbl, clk, rstn, cond, msg)
`define SBX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- src/sbx_pkg.sv -----
`default_nettype none
package sbx_pkg;

    localparam int VALUE_WIDTH_DEF  = 32;
    localparam int RANDOM_WIDTH_DEF = 16;
    localparam int FRAC_W           = 16;
    localparam int N1_W             = 7;
    localparam int CFG_IDX_W        = 2;
    localparam longint ONE          = 65536;
    localparam logic [16:0] U_SCALE = 17'd65470;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST  = 2'd2;

    function automatic logic [63:0] sbx_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 64'd0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-(j+1)) in Q1.30, each the integer root of the one before
    function automatic logic [30:0] sbx_root(input int unsigned j);
        logic [63:0] r;
        r = sbx_isqrt(64'd2 << 60);
        for (int unsigned k = 0; k < j; k++) r = sbx_isqrt(r << 30);
        return r[30:0];
    endfunction

endpackage
`default_nettype wire

// ----- src/sbx_crossover_child_unit.sv -----
// Bounded SBX crossover, one child gene per parent gene pair.
// Input channel: i_in_valid / o_in_stall with parent_a, parent_b (Q16.16),
// random_fraction (Q0.RANDOM_WIDTH) and side_select. Output channel:
// o_out_valid / i_out_stall with child_value (Q16.16). A word moves at an
// edge where valid is high and stall is low.
// Configuration: i_cfg_we writes register i_cfg_index (0 lower bound,
// 1 upper bound, 2 distribution index) from i_cfg_data;
// write only while the pipeline is empty.
// Throughput: one word per cycle while the output is not stalled. The
// pipeline depth is set by the bit-serial beta divider (VW + 17 stages,
// VW capped at 32), two log2 squaring chains and two exp2 root chains
// of 16 stages each, and the divide by ni+1 (22 stages).
// Reset clears every stage valid bit and loads the register defaults
// (bounds 0 and 1.0, distribution index 1).
// A stalled output word holds; the whole pipeline freezes with it and
// o_in_stall rises, so nothing is dropped or repeated.
`default_nettype none
`include "assert_macros.svh"
module sbx_crossover_child_unit #(
    parameter int VALUE_WIDTH  = sbx_pkg::VALUE_WIDTH_DEF,
    parameter int RANDOM_WIDTH = sbx_pkg::RANDOM_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [VALUE_WIDTH-1:0]         i_parent_a,
    input  logic [VALUE_WIDTH-1:0]         i_parent_b,
    input  logic [RANDOM_WIDTH-1:0]        i_random_fraction,
    input  logic                           i_side_select,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [VALUE_WIDTH-1:0]         o_child_value,
    input  logic                           i_cfg_we,
    input  logic [sbx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [VALUE_WIDTH-1:0]         i_cfg_data
);
    import sbx_pkg::*;

    localparam int VW  = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int BW  = (VW > 17) ? VW : 18;
    localparam int QW  = VW + FRAC_W + 1;
    localparam int XW1 = QW + 1;
    localparam int AW  = FRAC_W + 2;
    localparam int PRW = AW + FRAC_W;
    localparam int BDW = 2 * FRAC_W + 1;
    localparam int UPW = RANDOM_WIDTH + 17;

    typedef struct packed {
        logic [VW-1:0]        diff;
        logic signed [VW-1:0] mean;
        logic [FRAC_W-1:0]    u;
        logic                 side;
        logic                 eq;
        logic                 zero;
    } t_sb;
    localparam int SBW = $bits(t_sb);

    logic w_en;
    logic r_out_vld;
    logic [VW-1:0] r_out_child;

    assign w_en        = !(r_out_vld && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_out_vld;
    assign o_child_value = VALUE_WIDTH'(r_out_child);

    // configuration
    logic signed [BW-1:0] r_lower;
    logic signed [BW-1:0] r_upper;
    logic [5:0]           r_dist;
    logic [N1_W-1:0]      w_n1;

    assign w_n1 = N1_W'(r_dist) + N1_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= BW'(ONE);
            r_dist  <= 6'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOWER: r_lower <= BW'($signed(i_cfg_data[VW-1:0]));
                CFG_UPPER: r_upper <= BW'($signed(i_cfg_data[VW-1:0]));
                CFG_DIST:  r_dist  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // stage 1: mean, spread, scaled random
    logic signed [VW-1:0] w_a;
    logic signed [VW-1:0] w_b;
    logic signed [VW:0]   w_sum;
    logic signed [VW:0]   w_dab;
    logic [UPW-1:0]       w_uprod;
    t_sb                  w_sb1;

    assign w_a     = $signed(i_parent_a[VW-1:0]);
    assign w_b     = $signed(i_parent_b[VW-1:0]);
    assign w_sum   = (VW+1)'(w_a) + (VW+1)'(w_b);
    assign w_dab   = (VW+1)'(w_a) - (VW+1)'(w_b);
    assign w_uprod = UPW'(i_random_fraction) * UPW'(U_SCALE);

    always_comb begin
        w_sb1.diff = w_dab[VW] ? VW'(-w_dab) : VW'(w_dab);
        w_sb1.mean = w_sum[VW:1];
        w_sb1.u    = w_uprod[RANDOM_WIDTH +: FRAC_W];
        w_sb1.side = i_side_select;
        w_sb1.eq   = (w_a == w_b);
        w_sb1.zero = 1'b0;
    end

    logic                 r1_vld;
    logic signed [VW-1:0] r1_lo;
    logic signed [VW-1:0] r1_hi;
    t_sb                  r1_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_lo <= (w_a < w_b) ? w_a : w_b;
            r1_hi <= (w_a < w_b) ? w_b : w_a;
            r1_sb <= w_sb1;
        end
    end

    // stage 2: distance to the nearer bound, saturated at zero
    logic signed [BW+1:0] w_dlo;
    logic signed [BW+1:0] w_dhi;
    logic signed [BW+1:0] w_mn_s;
    logic [VW-1:0]        w_mn;

    assign w_dlo  = (BW+2)'(r1_lo) - (BW+2)'(r_lower);
    assign w_dhi  = (BW+2)'(r_upper) - (BW+2)'(r1_hi);
    assign w_mn_s = (w_dhi < w_dlo) ? w_dhi : w_dlo;
    assign w_mn   = w_mn_s[BW+1] ? '0 : VW'(w_mn_s);

    // beta divider: (mn << 17) / diff, one quotient bit a stage
    logic          r_dv_vld [QW+1];
    logic [VW-1:0] r_dv_rem [QW+1];
    logic [QW-1:0] r_dv_num [QW+1];
    logic [QW-1:0] r_dv_q   [QW+1];
    t_sb           r_dv_sb  [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_vld[0] <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_rem[0] <= '0;
            r_dv_num[0] <= {w_mn, (FRAC_W+1)'(0)};
            r_dv_q[0]   <= '0;
            r_dv_sb[0]  <= r1_sb;
        end
    end

    for (genvar g = 1; g <= QW; g++) begin : g_bdiv
        logic [VW:0] w_t;
        logic        w_ge;
        assign w_t  = {r_dv_rem[g-1], r_dv_num[g-1][QW-1]};
        assign w_ge = (w_t >= {1'b0, r_dv_sb[g-1].diff});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[g] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[g] <= r_dv_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[g] <= w_ge ? VW'(w_t - {1'b0, r_dv_sb[g-1].diff}) : VW'(w_t);
                r_dv_num[g] <= r_dv_num[g-1] << 1;
                r_dv_q[g]   <= {r_dv_q[g-1][QW-2:0], w_ge};
                r_dv_sb[g]  <= r_dv_sb[g-1];
            end
        end
    end

    // stage 3: beta
    logic           r3_vld;
    logic [XW1-1:0] r3_beta;
    t_sb            r3_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r_dv_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_beta <= XW1'(ONE) + XW1'(r_dv_q[QW]);
            r3_sb   <= r_dv_sb[QW];
        end
    end

    // beta^-(ni+1)
    logic           w_p1_vld;
    logic [AW-1:0]  w_inv;
    logic [SBW-1:0] w_p1_sb;

    sbx_pow #(
        .XW      (XW1),
        .OW      (AW),
        .USE_DIV (1'b0),
        .SW      (SBW)
    ) u_pow_beta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r3_vld),
        .i_x     (r3_beta),
        .i_neg   (1'b1),
        .i_n1    (w_n1),
        .i_sb    (SBW'(r3_sb)),
        .o_vld   (w_p1_vld),
        .o_y     (w_inv),
        .o_sb    (w_p1_sb)
    );

    // stage 4: alpha
    logic          r4_vld;
    logic [AW-1:0] r4_alpha;
    t_sb           r4_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= w_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_alpha <= AW'(2 * ONE) - ((w_inv > AW'(ONE)) ? AW'(ONE) : w_inv);
            r4_sb    <= t_sb'(w_p1_sb);
        end
    end

    // stage 5: alpha * u
    logic           r5_vld;
    logic [PRW-1:0] r5_prod;
    t_sb            r5_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_prod <= PRW'(r4_alpha) * PRW'(r4_sb.u);
            r5_sb   <= r4_sb;
        end
    end

    // stage 6: contracting or expanding operand
    logic          w_contract;
    logic [AW-1:0] w_x;
    logic [AW-1:0] w_d;
    t_sb           w_sb6;
    logic          r6_vld;
    logic [AW-1:0] r6_x;
    logic          r6_neg;
    t_sb           r6_sb;

    assign w_contract = (r5_prod <= (PRW'(1) << (2 * FRAC_W)));
    assign w_x        = r5_prod[PRW-1:FRAC_W];

    always_comb begin
        w_d = AW'(2 * ONE) - w_x;
        if (w_d == '0) w_d = AW'(1);
    end

    always_comb begin
        w_sb6      = r5_sb;
        w_sb6.zero = w_contract && (w_x == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_x   <= w_contract ? w_x : w_d;
            r6_neg <= !w_contract;
            r6_sb  <= w_sb6;
        end
    end

    // (ni+1)-th root of the operand, or of its reciprocal when expanding
    logic           w_p2_vld;
    logic [BDW-1:0] w_bd;
    logic [SBW-1:0] w_p2_sb;

    sbx_pow #(
        .XW      (AW),
        .OW      (BDW),
        .USE_DIV (1'b1),
        .SW      (SBW)
    ) u_pow_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r6_vld),
        .i_x     (r6_x),
        .i_neg   (r6_neg),
        .i_n1    (w_n1),
        .i_sb    (SBW'(r6_sb)),
        .o_vld   (w_p2_vld),
        .o_y     (w_bd),
        .o_sb    (w_p2_sb)
    );

    // stage 7: partial products of the root times diff
    t_sb               w_sb7;
    logic [BDW-1:0]    w_bdm;
    logic              r7_vld;
    logic [VW+16:0]    r7_pl;
    logic [VW+15:0]    r7_ph;
    t_sb               r7_sb;

    assign w_sb7 = t_sb'(w_p2_sb);
    assign w_bdm = w_sb7.zero ? '0 : w_bd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (w_en) begin
            r7_vld <= w_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_pl <= (VW+17)'(w_bdm[FRAC_W:0]) * (VW+17)'(w_sb7.diff);
            r7_ph <= (VW+16)'(w_bdm[BDW-1:FRAC_W+1]) * (VW+16)'(w_sb7.diff);
            r7_sb <= w_sb7;
        end
    end

    // stage 8: spread term, low bits only since the child wraps
    logic          r8_vld;
    logic [VW-1:0] r8_delta;
    t_sb           r8_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (w_en) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_delta <= r7_ph[VW-1:0] + r7_pl[VW+16:FRAC_W+1];
            r8_sb    <= r7_sb;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r8_sb.eq) r_out_child <= r8_sb.mean;
            else if (r8_sb.side) r_out_child <= r8_sb.mean + r8_delta;
            else r_out_child <= r8_sb.mean - r8_delta;
        end
    end

    `SBX_ASSERT_NEXT(a_freeze, i_clk, i_rst_n, !w_en, $stable(r1_vld) && $stable(r_dv_vld[QW]) && $stable(r8_vld) && $stable(r_out_vld), "pipeline advanced while stalled")
    `SBX_ASSERT_NEXT(a_eq_mean, i_clk, i_rst_n, w_en && r8_vld && r8_sb.eq, r_out_child == $past(r8_sb.mean), "equal parents did not give the mean")
    `SBX_ASSERT(a_out_src, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(r8_vld), "output word without a source")

endmodule
`default_nettype wire

// ----- src/sbx_pow.sv -----
`default_nettype none
// x -> 2^(+/- op(log2 x)), op is a multiply or a truncating divide by n1
module sbx_pow #(
    parameter int XW      = 18,
    parameter int OW      = 18,
    parameter bit USE_DIV = 1'b0,
    parameter int SW      = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [XW-1:0]             i_x,
    input  logic                      i_neg,
    input  logic [sbx_pkg::N1_W-1:0]  i_n1,
    input  logic [SW-1:0]             i_sb,
    output logic                      o_vld,
    output logic [OW-1:0]             o_y,
    output logic [SW-1:0]             o_sb
);
    import sbx_pkg::*;

    localparam int PW   = $clog2(XW);
    localparam int LW   = PW + 1 + FRAC_W;
    localparam int MW   = LW;
    localparam int OPW  = USE_DIV ? MW : MW + N1_W;
    localparam int EW   = OPW + 1;
    localparam int IPW  = EW - FRAC_W;
    localparam int NST  = 16;

    // leading one
    logic          r0_vld;
    logic [XW-1:0] r0_x;
    logic [PW-1:0] r0_p;
    logic          r0_neg;
    logic [SW-1:0] r0_sb;
    logic [PW-1:0] w_p;

    always_comb begin
        w_p = '0;
        for (int i = 0; i < XW; i++) begin
            if (i_x[i]) w_p = PW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_x   <= i_x;
            r0_p   <= w_p;
            r0_neg <= i_neg;
            r0_sb  <= i_sb;
        end
    end

    // log2 squaring stages, index 0 holds the normalized mantissa
    logic          r_lg_vld [NST+1];
    logic [30:0]   r_lg_y   [NST+1];
    logic [15:0]   r_lg_f   [NST+1];
    logic [PW-1:0] r_lg_p   [NST+1];
    logic          r_lg_neg [NST+1];
    logic [SW-1:0] r_lg_sb  [NST+1];
    logic [63:0]   w_xw;
    logic [63:0]   w_norm;
    logic [6:0]    w_p7;

    always_comb begin
        w_xw = 64'(r0_x);
        w_p7 = 7'(r0_p);
        if (w_p7 >= 7'd30) w_norm = w_xw >> (w_p7 - 7'd30);
        else w_norm = w_xw << (7'd30 - w_p7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_lg_vld[0] <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lg_y[0]   <= w_norm[30:0];
            r_lg_f[0]   <= '0;
            r_lg_p[0]   <= r0_p;
            r_lg_neg[0] <= r0_neg;
            r_lg_sb[0]  <= r0_sb;
        end
    end

    for (genvar k = 1; k <= NST; k++) begin : g_log
        logic [61:0] w_sq;
        logic [31:0] w_t;
        assign w_sq = 62'(r_lg_y[k-1]) * 62'(r_lg_y[k-1]);
        assign w_t  = w_sq[61:30];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lg_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_lg_vld[k] <= r_lg_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lg_y[k]   <= w_t[31] ? w_t[31:1] : w_t[30:0];
                r_lg_f[k]   <= r_lg_f[k-1] | (w_t[31] ? (16'd1 << (NST - k)) : 16'd0);
                r_lg_p[k]   <= r_lg_p[k-1];
                r_lg_neg[k] <= r_lg_neg[k-1];
                r_lg_sb[k]  <= r_lg_sb[k-1];
            end
        end
    end

    // magnitude and sign of the exponent
    logic signed [LW-1:0] w_log;
    logic signed [PW:0]   w_ip_log;
    logic                 ra_vld;
    logic [MW-1:0]        ra_mag;
    logic                 ra_s;
    logic [SW-1:0]        ra_sb;

    assign w_ip_log = $signed({1'b0, r_lg_p[NST]}) - $signed((PW+1)'(FRAC_W));
    assign w_log    = {w_ip_log, r_lg_f[NST]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_vld <= 1'b0;
        end else if (i_en) begin
            ra_vld <= r_lg_vld[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_mag <= w_log[LW-1] ? MW'(-w_log) : MW'(w_log);
            ra_s   <= w_log[LW-1] ^ r_lg_neg[NST];
            ra_sb  <= r_lg_sb[NST];
        end
    end

    logic           w_op_vld;
    logic [OPW-1:0] w_op_val;
    logic           w_op_s;
    logic [SW-1:0]  w_op_sb;

    if (USE_DIV) begin : g_div
        // restoring divide by n1, one quotient bit a stage
        logic                 r_dv_vld [MW+1];
        logic [N1_W-1:0]      r_dv_rem [MW+1];
        logic [MW-1:0]        r_dv_num [MW+1];
        logic [MW-1:0]        r_dv_q   [MW+1];
        logic                 r_dv_s   [MW+1];
        logic [SW-1:0]        r_dv_sb  [MW+1];

        always_comb begin
            r_dv_vld[0] = ra_vld;
            r_dv_rem[0] = '0;
            r_dv_num[0] = ra_mag;
            r_dv_q[0]   = '0;
            r_dv_s[0]   = ra_s;
            r_dv_sb[0]  = ra_sb;
        end

        for (genvar g = 1; g <= MW; g++) begin : g_st
            logic [N1_W:0] w_t;
            logic          w_ge;
            assign w_t  = {r_dv_rem[g-1], r_dv_num[g-1][MW-1]};
            assign w_ge = (w_t >= {1'b0, i_n1});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_dv_vld[g] <= r_dv_vld[g-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dv_rem[g] <= w_ge ? N1_W'(w_t - {1'b0, i_n1}) : N1_W'(w_t);
                    r_dv_num[g] <= r_dv_num[g-1] << 1;
                    r_dv_q[g]   <= {r_dv_q[g-1][MW-2:0], w_ge};
                    r_dv_s[g]   <= r_dv_s[g-1];
                    r_dv_sb[g]  <= r_dv_sb[g-1];
                end
            end
        end

        assign w_op_vld = r_dv_vld[MW];
        assign w_op_val = r_dv_q[MW];
        assign w_op_s   = r_dv_s[MW];
        assign w_op_sb  = r_dv_sb[MW];
    end else begin : g_mul
        logic           r_m_vld;
        logic [OPW-1:0] r_m_val;
        logic           r_m_s;
        logic [SW-1:0]  r_m_sb;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_vld <= 1'b0;
            end else if (i_en) begin
                r_m_vld <= ra_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m_val <= OPW'(ra_mag) * OPW'(i_n1);
                r_m_s   <= ra_s;
                r_m_sb  <= ra_sb;
            end
        end

        assign w_op_vld = r_m_vld;
        assign w_op_val = r_m_val;
        assign w_op_s   = r_m_s;
        assign w_op_sb  = r_m_sb;
    end

    // exp2 stages, index 0 holds the signed exponent split
    logic                  r_ex_vld [NST+1];
    logic [30:0]           r_ex_m   [NST+1];
    logic [15:0]           r_ex_f   [NST+1];
    logic signed [IPW-1:0] r_ex_ip  [NST+1];
    logic [SW-1:0]         r_ex_sb  [NST+1];
    logic signed [EW-1:0]  w_e;

    assign w_e = w_op_s ? -$signed({1'b0, w_op_val}) : $signed({1'b0, w_op_val});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_ex_vld[0] <= w_op_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ex_m[0]  <= 31'h4000_0000;
            r_ex_f[0]  <= w_e[15:0];
            r_ex_ip[0] <= w_e[EW-1:FRAC_W];
            r_ex_sb[0] <= w_op_sb;
        end
    end

    for (genvar j = 1; j <= NST; j++) begin : g_exp
        localparam logic [30:0] RT = sbx_root(j - 1);
        logic [61:0] w_mm;
        assign w_mm = 62'(r_ex_m[j-1]) * 62'(RT);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ex_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_ex_vld[j] <= r_ex_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ex_m[j]  <= r_ex_f[j-1][NST-j] ? w_mm[60:30] : r_ex_m[j-1];
                r_ex_f[j]  <= r_ex_f[j-1];
                r_ex_ip[j] <= r_ex_ip[j-1];
                r_ex_sb[j] <= r_ex_sb[j-1];
            end
        end
    end

    // final scaling by the integer part
    logic signed [31:0] w_ip;
    logic signed [31:0] w_sh;
    logic signed [31:0] w_nsh;
    logic [63:0]        w_mw;
    logic [63:0]        w_y;
    logic               r_o_vld;
    logic [OW-1:0]      r_o_y;
    logic [SW-1:0]      r_o_sb;

    always_comb begin
        w_ip = 32'(r_ex_ip[NST]);
        if (w_ip > 32'sd32) w_ip = 32'sd32;
        w_sh  = w_ip - 32'sd14;
        w_nsh = -w_sh;
        w_mw  = 64'(r_ex_m[NST]);
        if (w_sh >= 32'sd0) w_y = w_mw << w_sh[5:0];
        else if (w_nsh >= 32'sd63) w_y = '0;
        else w_y = w_mw >> w_nsh[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_ex_vld[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_y  <= w_y[OW-1:0];
            r_o_sb <= r_ex_sb[NST];
        end
    end

    assign o_vld = r_o_vld;
    assign o_y   = r_o_y;
    assign o_sb  = r_o_sb;

endmodule
`default_nettype wire
